[hw/rtl/qte_pkg.sv]
`default_nettype none
package qte_pkg;

    localparam int CordicStagesDef = 16;
    localparam int AngTabLen       = 24;
    // Operand width: values up to about 2^33 in magnitude, with growth of the vector.
    localparam int OpW             = 40;
    localparam int AccW            = 32;
    localparam int QuatW           = 16;
    localparam int SqW             = 58;
    localparam int SqRootW         = 29;
    localparam int SqSteps         = 29;

    localparam logic signed [OpW-1:0]  OneQ28     = OpW'(64'sd268435456);
    localparam logic signed [AccW-1:0] Deg180Acc  = AccW'(64'sd1179648000);

    function automatic logic signed [AccW-1:0] ang_tab(input int idx);
        logic signed [AccW-1:0] v;
        unique case (idx)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466764;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [OpW-1:0]  x;
        logic signed [OpW-1:0]  y;
        logic signed [AccW-1:0] acc;
        logic                   zero;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] rx;
        logic signed [14:0] ry;
        logic signed [15:0] rz;
        logic               clamped;
    } t_res;

endpackage
`default_nettype wire

[hw/rtl/qte_stream_if.sv]
`default_nettype none
interface qte_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/qte_cordic_cell.sv]
`default_nettype none
// One vectoring step: rotate towards the x axis by atan(2^-STEP).
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire   i_clk,
    input  wire   i_en,
    input  t_vec  i_vec,
    output t_vec  o_vec
);
    t_vec r_vec;
    t_vec n_vec;
    logic signed [OpW-1:0] xs, ys;

    always_comb begin
        xs = i_vec.x >>> STEP;
        ys = i_vec.y >>> STEP;
        n_vec = i_vec;
        if (i_vec.y > 0) begin
            n_vec.x   = i_vec.x + ys;
            n_vec.y   = i_vec.y - xs;
            n_vec.acc = i_vec.acc + ang_tab(STEP);
        end else begin
            n_vec.x   = i_vec.x - ys;
            n_vec.y   = i_vec.y + xs;
            n_vec.acc = i_vec.acc - ang_tab(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end
    assign o_vec = r_vec;
endmodule
`default_nettype wire

[hw/rtl/qte_sqrt_cell.sv]
`default_nettype none
// One restoring square-root step (two radicand bits, one root bit).
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire [SqW-1:0]       i_rem,
    input  wire [SqRootW-1:0]   i_root,
    input  wire [SqW-1:0]       i_rad,
    output logic [SqW-1:0]      o_rem,
    output logic [SqRootW-1:0]  o_root,
    output logic [SqW-1:0]      o_rad
);
    logic [SqW+1:0] trial;
    logic [SqW+1:0] rem_sh;
    logic [SqW-1:0] r_rem, r_rad;
    logic [SqRootW-1:0] r_root;

    always_comb begin
        rem_sh = {i_rem, i_rad[SqW-1 -: 2]};
        trial  = {(SqW+2-SqRootW-2)'(0), i_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= i_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= SqW'(rem_sh - trial);
                r_root <= {i_root[SqRootW-2:0], 1'b1};
            end else begin
                r_rem  <= SqW'(rem_sh);
                r_root <= {i_root[SqRootW-2:0], 1'b0};
            end
        end
    end
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
endmodule
`default_nettype wire

[hw/rtl/quaternion_to_euler_angles.sv]
`default_nettype none
// Channel  | Dir | Beat contents
// i_quat   | in  | quat_w, quat_x, quat_y, quat_z (signed Q2.14 each)
// o_euler  | out | rot_about_x, rot_about_y, rot_about_z, asin_clamped
//
// Fully pipelined: one beat a cycle unless o_euler stalls and freezes the chain; the
// latency is set by the square-root cells followed by the CORDIC
// cells of the pitch path (the roll and yaw rows run alongside and are delayed to match).
// Reset clears the valid bits only; payload registers carry no reset.
// Stalls freeze the whole chain; the last stage is the output register.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    qte_stream_if.sink   i_quat,
    qte_stream_if.source o_euler
);
    localparam int NS  = (CORDIC_STAGES < AngTabLen) ? CORDIC_STAGES : AngTabLen;
    localparam int LAT = 4 + SqSteps + 1 + NS + 1;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    // Stage 1: register the parts.
    logic signed [QuatW-1:0] r_w, r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_quat.data[63:48];
            r_x <= i_quat.data[47:32];
            r_y <= i_quat.data[31:16];
            r_z <= i_quat.data[15:0];
        end
    end

    // Stage 2: products.
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= r_w * r_x; r_yz <= r_y * r_z; r_xx <= r_x * r_x;
            r_yy <= r_y * r_y; r_wz <= r_w * r_z; r_xy <= r_x * r_y;
            r_zz <= r_z * r_z; r_wy <= r_w * r_y; r_zx <= r_z * r_x;
        end
    end

    // Stage 3: operands, clamp of the asin argument.
    logic signed [OpW-1:0] r_ax, r_ay, r_zx_o, r_zy, r_t;
    logic r_clamp;
    logic signed [OpW-1:0] t_raw;
    always_comb t_raw = 2 * (OpW'(r_wy) - OpW'(r_zx));
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ay   <= 2 * (OpW'(r_wx) + OpW'(r_yz));
            r_ax   <= OneQ28 - 2 * (OpW'(r_xx) + OpW'(r_yy));
            r_zy   <= 2 * (OpW'(r_wz) + OpW'(r_xy));
            r_zx_o <= OneQ28 - 2 * (OpW'(r_yy) + OpW'(r_zz));
            if (t_raw > OneQ28) begin
                r_t <= OneQ28; r_clamp <= 1'b1;
            end else if (t_raw < -OneQ28) begin
                r_t <= -OneQ28; r_clamp <= 1'b1;
            end else begin
                r_t <= t_raw; r_clamp <= 1'b0;
            end
        end
    end

    // Stage 4: radicand 1 - t*t; |t| fits 29 bits, so one 29x29 multiply.
    logic [28:0] t_mag;
    logic [SqW-1:0] r_rad0;
    assign t_mag = 29'(r_t < 0 ? -r_t : r_t);
    always_ff @(posedge i_clk) begin
        if (en) r_rad0 <= SqW'(58'd1 << 56) - SqW'(t_mag) * SqW'(t_mag);
    end

    // Square-root cell row; roll, yaw and pitch data travel alongside.
    localparam int SD = SqSteps + 1;
    logic [SqW-1:0]     rem_c [SqSteps+1];
    logic [SqRootW-1:0] root_c[SqSteps+1];
    logic [SqW-1:0]     rad_c [SqSteps+1];
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;
    assign rad_c[0]  = r_rad0;
    for (genvar g = 0; g < SqSteps; g++) begin : g_sq
        qte_sqrt_cell #(.STEP(g)) u_sq (
            .i_clk(i_clk), .i_en(en),
            .i_rem(rem_c[g]), .i_root(root_c[g]), .i_rad(rad_c[g]),
            .o_rem(rem_c[g+1]), .o_root(root_c[g+1]), .o_rad(rad_c[g+1])
        );
    end

    logic signed [OpW-1:0] r_dx_ax[SD], r_dx_ay[SD], r_dz_ax[SD], r_dz_ay[SD], r_dt[SD];
    logic r_dcl[SD];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx_ax[0] <= r_ax; r_dx_ay[0] <= r_ay;
            r_dz_ax[0] <= r_zx_o; r_dz_ay[0] <= r_zy;
            r_dt[0] <= r_t; r_dcl[0] <= r_clamp;
            for (int k = 1; k < SD; k++) begin
                r_dx_ax[k] <= r_dx_ax[k-1]; r_dx_ay[k] <= r_dx_ay[k-1];
                r_dz_ax[k] <= r_dz_ax[k-1]; r_dz_ay[k] <= r_dz_ay[k-1];
                r_dt[k] <= r_dt[k-1]; r_dcl[k] <= r_dcl[k-1];
            end
        end
    end

    // Quadrant pre-rotation of each vector.
    function automatic t_vec pre(input logic signed [OpW-1:0] y,
                                 input logic signed [OpW-1:0] x);
        t_vec v;
        v.zero = (x == 0) && (y == 0);
        if (x < 0) begin
            v.acc = (y >= 0) ? Deg180Acc : -Deg180Acc;
            v.x = -x; v.y = -y;
        end else begin
            v.acc = '0; v.x = x; v.y = y;
        end
        return v;
    endfunction

    t_vec r_pv[3];
    logic r_pcl;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pv[0] <= pre(r_dx_ay[SD-1], r_dx_ax[SD-1]);
            r_pv[1] <= pre(r_dt[SD-1], OpW'($signed({1'b0, root_c[SqSteps]})));
            r_pv[2] <= pre(r_dz_ay[SD-1], r_dz_ax[SD-1]);
            r_pcl   <= r_dcl[SD-1];
        end
    end

    // Three CORDIC cell rows.
    t_vec chain[3][NS+1];
    logic r_ccl[NS];
    for (genvar a = 0; a < 3; a++) begin : g_ax
        assign chain[a][0] = r_pv[a];
        for (genvar s = 0; s < NS; s++) begin : g_st
            qte_cordic_cell #(.STEP(s)) u_c (
                .i_clk(i_clk), .i_en(en),
                .i_vec(chain[a][s]), .o_vec(chain[a][s+1])
            );
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ccl[0] <= r_pcl;
            for (int k = 1; k < NS; k++) r_ccl[k] <= r_ccl[k-1];
        end
    end

    // Round half away from zero, saturate.
    function automatic logic signed [15:0] fin(input t_vec v, input int lim);
        logic signed [AccW-1:0] r;
        if (v.zero) return '0;
        if (v.acc >= 0) r = (v.acc + 32'sd32768) >>> 16;
        else            r = -((-v.acc + 32'sd32768) >>> 16);
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r[15:0];
    endfunction

    t_res r_out;
    logic signed [15:0] ry16;
    assign ry16 = fin(chain[1][NS], 9000);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.rx      <= fin(chain[0][NS], 18000);
            r_out.ry      <= ry16[14:0];
            r_out.rz      <= fin(chain[2][NS], 18000);
            r_out.clamped <= r_ccl[NS-1];
        end
    end

    assign o_euler.valid = r_vld[LAT-1];
    assign o_euler.data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && !o_euler.ready |=> o_euler.valid && $stable(o_euler.data))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_euler.valid |-> i_quat.ready)
        else $error("pipeline stalled with empty output");
    a_ry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> ($signed(r_out.ry) <= 9000 && $signed(r_out.ry) >= -9000))
        else $error("pitch out of range");
endmodule
`default_nettype wire
